[hw/rtl/ecg_baseline_drift_removal_macros.svh]
// Assertion macros for the drift removal RTL (included by ebdr_ctrl).
// Relies on clk and arst_n being visible in the including module.
`ifndef ECG_BASELINE_DRIFT_REMOVAL_MACROS_SVH
`define ECG_BASELINE_DRIFT_REMOVAL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EBDR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ebdr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EBDR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ebdr: next-cycle check failed");

`endif

[hw/rtl/ebdr_pkg.sv]
// Shared types and constants for the ECG baseline drift removal block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package ebdr_pkg;

	localparam int LEAD_W    = 4;
	localparam int MODE_W    = 3;
	localparam int WIN_TBL_W = 12;

	localparam logic [MODE_W-1:0] MODE_BYPASS = 3'd0;
	localparam logic [MODE_W-1:0] MODE_W3400  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_W2250  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_W1700  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_W1350  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_W1048  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_W672   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_W500   = 3'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the accepted item
		logic rd;        // read old sample and delayed tap
		logic upd;       // update sum, ring, pointer; start divide
		logic div_step;  // one quotient bit
		logic out_load;  // move result into the output register
	} ebdr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bypass;    // incoming item needs no filtering
		logic div_done;  // all quotient bits produced
		logic out_busy;  // output register holds an item not yet taken
	} ebdr_sts_t;

	// Window length per mode; bypass counts as a window of one.
	function automatic logic [WIN_TBL_W-1:0] win_table(input logic [MODE_W-1:0] mode);
		logic [WIN_TBL_W-1:0] len;
		unique case (mode)
			MODE_BYPASS: len = 12'd1;
			MODE_W3400:  len = 12'd3400;
			MODE_W2250:  len = 12'd2250;
			MODE_W1700:  len = 12'd1700;
			MODE_W1350:  len = 12'd1350;
			MODE_W1048:  len = 12'd1048;
			MODE_W672:   len = 12'd672;
			MODE_W500:   len = 12'd500;
			default:     len = 12'd1;
		endcase
		return len;
	endfunction

endpackage

[hw/rtl/ebdr_ctrl.sv]
// Sequencing state machine for the drift removal block.
// Depends on ebdr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ecg_baseline_drift_removal_macros.svh"

module ebdr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_valid,
	output logic               s_ready,
	input  ebdr_pkg::ebdr_sts_t sts,
	output ebdr_pkg::ebdr_cmd_t cmd
);
	import ebdr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign s_ready      = (state_q == ST_IDLE);
	assign accept       = s_valid && s_ready;
	assign cmd.load     = accept;
	assign cmd.rd       = (state_q == ST_READ);
	assign cmd.upd      = (state_q == ST_UPD);
	assign cmd.div_step = (state_q == ST_DIV) && !sts.div_done;
	assign cmd.out_load = (state_q == ST_DONE) && !sts.out_busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = sts.bypass ? ST_DONE : ST_READ;
				end
			end
			ST_READ: state_d = ST_UPD;
			ST_UPD:  state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`EBDR_ASSERT_NEXT(a_accept_step, accept, (state_q == ST_READ) || (state_q == ST_DONE))
	`EBDR_ASSERT_NEXT(a_div_exit, (state_q == ST_DIV) && sts.div_done, state_q == ST_DONE)
	`EBDR_ASSERT_NOW(a_no_overwrite, cmd.out_load, !sts.out_busy && (state_q == ST_DONE))

endmodule

[hw/rtl/ebdr_datapath.sv]
// Datapath: per-lead sums and pointers, sample ring memory, divider, output register.
// Depends on ebdr_pkg; driven by commands from ebdr_ctrl.
`timescale 1ns / 1ps

module ebdr_datapath #(
	parameter int NUM_LEADS   = 12,
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               mode_we,
	input  logic [ebdr_pkg::MODE_W-1:0]        mode_wdata,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	input  logic [ebdr_pkg::LEAD_W-1:0]        lead_in,
	input  ebdr_pkg::ebdr_cmd_t                cmd,
	output ebdr_pkg::ebdr_sts_t                sts,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [SAMPLE_BITS:0]        out_sample,
	output logic [ebdr_pkg::LEAD_W-1:0]        out_lead
);
	import ebdr_pkg::*;

	localparam int OUT_W     = SAMPLE_BITS + 1;
	localparam int PTR_W     = $clog2(MAX_WINDOW);
	localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
	localparam int WN_W      = (WIN_W > WIN_TBL_W) ? WIN_W : WIN_TBL_W;
	localparam int SUM_W     = SAMPLE_BITS + PTR_W + 1;
	localparam int CNT_W     = $clog2(SUM_W + 1);
	localparam int LIDX_W    = (NUM_LEADS > 1) ? $clog2(NUM_LEADS) : 1;
	localparam int MEM_DEPTH = NUM_LEADS * MAX_WINDOW;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	function automatic logic [WIN_W-1:0] clamp_win(input logic [MODE_W-1:0] m);
		logic [WN_W-1:0] t;
		t = WN_W'(win_table(m));
		if (t > WN_W'(MAX_WINDOW)) begin
			return WIN_W'(MAX_WINDOW);
		end
		return WIN_W'(t);
	endfunction

	// Configuration and per-lead state
	logic [MODE_W-1:0]        mode_q;
	logic signed [SUM_W-1:0]  sum_q  [NUM_LEADS];
	logic [PTR_W-1:0]         ptr_q  [NUM_LEADS];
	logic [WIN_W-1:0]         fill_q [NUM_LEADS];
	logic [WIN_W-1:0]         win_n;
	logic [WIN_W-1:0]         win_new;

	// Captured item
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [LEAD_W-1:0]             lead_q;
	logic                          bypass_q;
	logic [LIDX_W-1:0]             lidx;

	// Ring memory and read stage
	logic signed [SAMPLE_BITS-1:0] ring_mem [MEM_DEPTH];
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic signed [SAMPLE_BITS-1:0] tapd_q;
	logic                          tap_valid_q;
	logic [PTR_W-1:0]              cur_ptr;
	logic [WIN_W:0]                tap_sum;
	logic [WIN_W:0]                tap_wrap;
	logic [PTR_W-1:0]              tap_idx;
	logic [ADDR_W-1:0]             lead_base;
	logic [ADDR_W-1:0]             addr_p;
	logic [ADDR_W-1:0]             addr_t;
	logic                          full;

	// Update stage
	logic signed [SAMPLE_BITS-1:0] old_eff;
	logic signed [SUM_W-1:0]       new_sum;
	logic [SUM_W-1:0]              sum_mag;

	// Divider
	logic [WIN_W-1:0]              rem_q;
	logic [SUM_W-1:0]              dq_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          neg_q;
	logic signed [SAMPLE_BITS-1:0] tap_keep_q;
	logic [WIN_W:0]                rem_sh;
	logic [WIN_W:0]                rem_sub;
	logic                          rem_ge;

	// Result
	logic signed [OUT_W-1:0] quot;
	logic signed [OUT_W-1:0] quot_s;
	logic signed [OUT_W-1:0] result;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_sample_q;
	logic [LEAD_W-1:0]       out_lead_q;

	assign win_n   = clamp_win(mode_q);
	assign win_new = clamp_win(mode_wdata);
	assign lidx    = lead_q[LIDX_W-1:0];
	assign cur_ptr = ptr_q[lidx];
	assign full    = (fill_q[lidx] >= win_n);

	// Delayed tap sits half a window ahead of the write pointer (ring counts down).
	assign tap_sum  = (WIN_W + 1)'(cur_ptr) + (WIN_W + 1)'(win_n >> 1);
	assign tap_wrap = (tap_sum >= (WIN_W + 1)'(win_n)) ? tap_sum - (WIN_W + 1)'(win_n) : tap_sum;
	assign tap_idx  = tap_wrap[PTR_W-1:0];

	assign lead_base = ADDR_W'(lidx) * ADDR_W'(MAX_WINDOW);
	assign addr_p    = lead_base + ADDR_W'(cur_ptr);
	assign addr_t    = lead_base + ADDR_W'(tap_idx);

	// Entries not yet written since the last clear read as zero.
	assign old_eff = full ? old_q : '0;
	assign new_sum = sum_q[lidx] + SUM_W'(sample_q) - SUM_W'(old_eff);
	assign sum_mag = new_sum[SUM_W-1] ? -new_sum : new_sum;

	assign rem_sh  = {rem_q, dq_q[SUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, win_n};
	assign rem_ge  = (rem_sh >= {1'b0, win_n});

	assign quot   = dq_q[OUT_W-1:0];
	assign quot_s = neg_q ? -quot : quot;
	assign result = bypass_q ? OUT_W'(sample_q) : OUT_W'(tap_keep_q) - quot_s;

	assign sts.bypass   = (mode_q == MODE_BYPASS)
	                   || ({1'b0, lead_in} >= (LEAD_W + 1)'(NUM_LEADS));
	assign sts.div_done = (cnt_q == '0);
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_lead   = out_lead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BYPASS;
			for (int i = 0; i < NUM_LEADS; i++) begin
				sum_q[i]  <= '0;
				ptr_q[i]  <= '0;  // bypass window of one
				fill_q[i] <= '0;
			end
		end else if (mode_we) begin
			mode_q <= mode_wdata;
			for (int i = 0; i < NUM_LEADS; i++) begin
				sum_q[i]  <= '0;
				ptr_q[i]  <= PTR_W'(win_new - 1'b1);
				fill_q[i] <= '0;
			end
		end else if (cmd.upd) begin
			sum_q[lidx] <= new_sum;
			ptr_q[lidx] <= (cur_ptr == '0) ? PTR_W'(win_n - 1'b1) : cur_ptr - 1'b1;
			if (!full) begin
				fill_q[lidx] <= fill_q[lidx] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample_in;
			lead_q   <= lead_in;
			bypass_q <= sts.bypass;
		end
		if (cmd.rd) begin
			tap_valid_q <= full || (tap_idx > cur_ptr);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			ring_mem[addr_p] <= sample_q;
		end
		if (cmd.rd) begin
			old_q  <= ring_mem[addr_p];
			tapd_q <= ring_mem[addr_t];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.upd) begin
			cnt_q <= CNT_W'(SUM_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			rem_q      <= '0;
			dq_q       <= sum_mag;
			neg_q      <= new_sum[SUM_W-1];
			tap_keep_q <= tap_valid_q ? tapd_q : '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? WIN_W'(rem_sub) : WIN_W'(rem_sh);
			dq_q  <= {dq_q[SUM_W-2:0], rem_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_sample_q <= result;
			out_lead_q   <= lead_q;
		end
	end

endmodule

[hw/rtl/ecg_baseline_drift_removal.sv]
// Multi-lead ECG baseline wander remover: each item is one sample of one lead; the
// result is the sample from half a window earlier minus the lead's window mean
// (quotient truncated toward zero), or the input itself in bypass mode or for a
// lead number of NUM_LEADS or more. Each lead keeps its own ring of samples, running
// sum and pointer; writing drift_mode restarts every lead with an empty window,
// and until a lead has seen a full window its missing samples count as zero.
// A filtered item passes from acceptance to the result register through one ring
// read, one update, then a restoring divider that yields one quotient bit per
// cycle over the 37-bit window sum, the done check and the output load; a bypassed
// item goes straight to the output load. The output load waits while the output
// register holds a result not yet taken. One item is in work at a time; the next
// item is taken in the cycle in which the previous result first sits in the output
// register. There is no clearing pass: per-lead fill counts mask unwritten ring
// entries, so the block is ready right after reset and right after a mode write.
// Depends on ebdr_pkg, ebdr_ctrl and ebdr_datapath.
`timescale 1ns / 1ps

module ecg_baseline_drift_removal #(
	parameter int NUM_LEADS   = 12,
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Mode register: 0 bypass, 1..7 window 3400/2250/1700/1350/1048/672/500
	input  logic                               drift_mode_we,
	input  logic [ebdr_pkg::MODE_W-1:0]        drift_mode_wdata,
	// Input items
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // sample_in
	input  logic [ebdr_pkg::LEAD_W-1:0]        s_axis_tuser,  // lead_index
	// Result items
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [((SAMPLE_BITS+8)/8)*8-1:0]   m_axis_tdata,  // sample_out
	output logic [ebdr_pkg::LEAD_W-1:0]        m_axis_tuser   // lead_out
);
	import ebdr_pkg::*;

	localparam int OUT_W       = SAMPLE_BITS + 1;
	localparam int OUT_TDATA_W = ((SAMPLE_BITS + 8) / 8) * 8;

	ebdr_cmd_t                     cmd;
	ebdr_sts_t                     sts;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic signed [OUT_W-1:0]       sample_out;

	// Drop the byte padding of the input; pad the result with zeros.
	assign sample_in    = s_axis_tdata[SAMPLE_BITS-1:0];
	assign m_axis_tdata = OUT_TDATA_W'($unsigned(sample_out));

	ebdr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ebdr_datapath #(
		.NUM_LEADS   (NUM_LEADS),
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (drift_mode_we),
		.mode_wdata (drift_mode_wdata),
		.sample_in  (sample_in),
		.lead_in    (s_axis_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_sample (sample_out),
		.out_lead   (m_axis_tuser)
	);

endmodule
